// ----- hdl/pevw_pkg.sv -----
`timescale 1ns / 1ps

package pevw_pkg;

   // Heading wrap: one half turn in rad4096 units, and the full turn used per wrap step
   localparam int HALF_TURN = 12868;
   localparam int FULL_TURN = 2 * HALF_TURN;
   // Worst-case number of wrap steps for a 17-bit heading change
   localparam int WRAP_STEPS = (65535 - HALF_TURN + FULL_TURN - 1) / FULL_TURN;

   // Timer increment per tick, in ms
   localparam int TICK_MS = 5;

   // Bit positions in the warning and armed masks
   localparam int BIT_ANGLE = 0;
   localparam int BIT_X     = 1;
   localparam int BIT_Y     = 2;
   localparam int BIT_TIMER = 3;
   localparam int BIT_TRANS = 4;
   localparam int BIT_ROT   = 5;
   localparam int MASK_W    = 6;

   // Field widths
   localparam int ACTION_W = 4;
   localparam int POS_W    = 16;
   localparam int ARM_W    = 17;
   localparam int TOL_W    = 15;
   localparam int REQ_DATA_W = 72;  // 65 payload bits padded to whole bytes
   localparam int RSP_DATA_W = 16;  // 12 payload bits padded to whole bytes

   // Configuration register indexes
   localparam logic CSR_ANGLE_TOL = 1'b0;
   localparam logic CSR_POS_TOL   = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK       = 4'd0,
      ACT_ARM_ANGLE  = 4'd1,
      ACT_ARM_X      = 4'd2,
      ACT_ARM_Y      = 4'd3,
      ACT_ARM_TIMER  = 4'd4,
      ACT_ARM_TRANS  = 4'd5,
      ACT_ARM_ROT    = 4'd6,
      ACT_INIT       = 4'd7,
      ACT_COLLECT    = 4'd8
   } action_type;

endpackage

// ----- hdl/position_event_watcher_core.sv -----
`timescale 1ns / 1ps

// Pose event watcher.
// Input channel req_*: one beat per action. req_tuser carries the action code,
// req_tdata the pose (x, y, heading) and the arm value. Every beat produces
// exactly one beat on rsp_*, carrying the pending warning bits (for collect, the
// bits it clears) and the armed watcher bits after that action.
// Configuration: csr_we with csr_index selects angle tolerance (0) or
// position tolerance (1); csr_wdata is taken at the same edge.
// An accepted beat waits in the input register and moves into the result
// register, raising rsp_tvalid, once that register is empty or being taken.
// Throughput: one beat per cycle while rsp_tready is high. The whole update of
// the watcher state is a single combinational pass between the input register
// and the result register; its longest path is the two 16x16 squares plus the
// 33-bit add and compare of the translation watcher.
// Reset (synchronous, active high) disarms every watcher, clears the pending
// bits, timer and reference pose, zeroes both tolerances and empties both
// pipeline registers.
// When the receiver stalls, the result register holds its beat, one more beat
// waits in the input register, and req_tready then drops until rsp moves.
module position_event_watcher_core (
   input  logic                            clock,
   input  logic                            reset,
   // slave side
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: pos_x[15:0], pos_y[31:16], pos_angle[47:32], arm_value[64:48], zeros above
   input  logic [pevw_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: action[3:0]
   input  logic [pevw_pkg::ACTION_W-1:0]   req_tuser,
   // master side
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: warning_mask[5:0], armed_mask[11:6], zeros above
   output logic [pevw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [pevw_pkg::TOL_W-1:0]      csr_wdata
);
   import pevw_pkg::*;

   localparam logic signed [17:0] HALF_S = 18'(HALF_TURN);
   localparam logic signed [17:0] FULL_S = 18'(FULL_TURN);

   // Configuration
   logic [TOL_W-1:0] angle_tol_ff;
   logic [TOL_W-1:0] pos_tol_ff;

   // Input stage
   logic                     in_valid_ff;
   action_type               in_action_ff;
   logic signed [POS_W-1:0]  in_x_ff;
   logic signed [POS_W-1:0]  in_y_ff;
   logic signed [POS_W-1:0]  in_a_ff;
   logic signed [ARM_W-1:0]  in_arm_ff;

   // Watcher state
   logic signed [POS_W-1:0]  target_angle_ff, target_angle_in;
   logic signed [POS_W-1:0]  target_x_ff, target_x_in;
   logic signed [POS_W-1:0]  target_y_ff, target_y_in;
   logic [POS_W-1:0]         timer_limit_ff, timer_limit_in;
   logic [31:0]              dist_limit_ff, dist_limit_in;
   logic signed [POS_W-1:0]  rot_limit_ff, rot_limit_in;
   logic [POS_W-1:0]         elapsed_ff, elapsed_in;
   logic signed [POS_W-1:0]  ref_x_ff, ref_x_in;
   logic signed [POS_W-1:0]  ref_y_ff, ref_y_in;
   logic signed [POS_W-1:0]  ref_a_ff, ref_a_in;
   logic [MASK_W-1:0]        pending_ff, pending_in;

   // Result stage
   logic                     rsp_valid_ff;
   logic [MASK_W-1:0]        rsp_warn_ff, rsp_warn_in;
   logic [MASK_W-1:0]        rsp_armed_ff, rsp_armed_in;

   logic advance;

   // Datapath terms
   logic signed [POS_W:0]    diff_a, diff_x, diff_y, diff_rx, diff_ry;
   logic [POS_W:0]           mag_a, mag_x, mag_y, mag_rx, mag_ry;
   logic                     hit_angle, hit_x, hit_y, hit_timer, hit_trans, hit_rot;
   logic [POS_W-1:0]         elapsed_inc;
   logic [31:0]              dx_sq, dy_sq;
   logic [32:0]              dist_sq;
   logic signed [17:0]       rot_d;
   logic signed [17:0]       rot_mag;
   logic [ARM_W-1:0]         arm_mag;
   logic [2*ARM_W-1:0]       arm_sq;
   logic [31:0]              arm_sq_sat;
   logic [MASK_W-1:0]        tick_pend;

   // Move one beat from the input register to the result register
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2*MASK_W){1'b0}}, rsp_armed_ff, rsp_warn_ff};

   // Capture configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_tol_ff <= '0;
         pos_tol_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ANGLE_TOL: angle_tol_ff <= csr_wdata;
            CSR_POS_TOL:   pos_tol_ff   <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff <= action_type'(req_tuser);
         in_x_ff      <= req_tdata[15:0];
         in_y_ff      <= req_tdata[31:16];
         in_a_ff      <= req_tdata[47:32];
         in_arm_ff    <= req_tdata[64:48];
      end
   end

   // Target windows
   always_comb begin
      diff_a = {in_a_ff[POS_W-1], in_a_ff} - {target_angle_ff[POS_W-1], target_angle_ff};
      diff_x = {in_x_ff[POS_W-1], in_x_ff} - {target_x_ff[POS_W-1], target_x_ff};
      diff_y = {in_y_ff[POS_W-1], in_y_ff} - {target_y_ff[POS_W-1], target_y_ff};
      mag_a  = diff_a[POS_W] ? 17'(-diff_a) : 17'(diff_a);
      mag_x  = diff_x[POS_W] ? 17'(-diff_x) : 17'(diff_x);
      mag_y  = diff_y[POS_W] ? 17'(-diff_y) : 17'(diff_y);
      hit_angle = (target_angle_ff != '0) && (mag_a <= {2'b00, angle_tol_ff});
      hit_x     = (target_x_ff != '0) && (mag_x < {2'b00, pos_tol_ff});
      hit_y     = (target_y_ff != '0) && (mag_y < {2'b00, pos_tol_ff});
   end

   // Timer
   assign elapsed_inc = elapsed_ff + POS_W'(TICK_MS);
   assign hit_timer   = (timer_limit_ff != '0) && (elapsed_inc >= timer_limit_ff);

   // Squared distance from the reference pose at full width
   always_comb begin
      diff_rx = {in_x_ff[POS_W-1], in_x_ff} - {ref_x_ff[POS_W-1], ref_x_ff};
      diff_ry = {in_y_ff[POS_W-1], in_y_ff} - {ref_y_ff[POS_W-1], ref_y_ff};
      mag_rx  = diff_rx[POS_W] ? 17'(-diff_rx) : 17'(diff_rx);
      mag_ry  = diff_ry[POS_W] ? 17'(-diff_ry) : 17'(diff_ry);
      dx_sq   = mag_rx[POS_W-1:0] * mag_rx[POS_W-1:0];
      dy_sq   = mag_ry[POS_W-1:0] * mag_ry[POS_W-1:0];
      dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
      hit_trans = (dist_limit_ff != '0) && (dist_sq >= {1'b0, dist_limit_ff});
   end

   // Wrap the heading change into one turn, then compare its magnitude
   always_comb begin
      rot_d = {{2{in_a_ff[POS_W-1]}}, in_a_ff} - {{2{ref_a_ff[POS_W-1]}}, ref_a_ff};
      for (int i = 0; i < WRAP_STEPS; i++) begin
         if (rot_d > HALF_S) begin
            rot_d = rot_d - FULL_S;
         end else if (rot_d < -HALF_S) begin
            rot_d = rot_d + FULL_S;
         end
      end
      rot_mag = rot_d[17] ? -rot_d : rot_d;
      hit_rot = (rot_limit_ff != '0) &&
                (rot_mag > $signed({{2{rot_limit_ff[POS_W-1]}}, rot_limit_ff}));
   end

   // Translation limit: square of the arm value's magnitude, saturated to 32 bits
   always_comb begin
      arm_mag    = in_arm_ff[ARM_W-1] ? (~in_arm_ff + 1'b1) : in_arm_ff;
      arm_sq     = arm_mag * arm_mag;
      arm_sq_sat = (arm_sq[2*ARM_W-1:32] != '0) ? '1 : arm_sq[31:0];
   end

   // Pending bits after a tick
   always_comb begin
      tick_pend = pending_ff;
      tick_pend[BIT_ANGLE] = tick_pend[BIT_ANGLE] | hit_angle;
      tick_pend[BIT_X]     = tick_pend[BIT_X] | hit_x;
      tick_pend[BIT_Y]     = tick_pend[BIT_Y] | hit_y;
      tick_pend[BIT_TIMER] = tick_pend[BIT_TIMER] | hit_timer;
      tick_pend[BIT_TRANS] = tick_pend[BIT_TRANS] | hit_trans;
      tick_pend[BIT_ROT]   = tick_pend[BIT_ROT] | hit_rot;
   end

   // Decode the action and form the next watcher state and the result
   always_comb begin
      target_angle_in = target_angle_ff;
      target_x_in     = target_x_ff;
      target_y_in     = target_y_ff;
      timer_limit_in  = timer_limit_ff;
      dist_limit_in   = dist_limit_ff;
      rot_limit_in    = rot_limit_ff;
      elapsed_in      = elapsed_ff;
      ref_x_in        = ref_x_ff;
      ref_y_in        = ref_y_ff;
      ref_a_in        = ref_a_ff;
      pending_in      = pending_ff;
      rsp_warn_in     = pending_ff;

      if (advance) begin
         unique case (in_action_ff)
            ACT_TICK: begin
               if (hit_angle) target_angle_in = '0;
               if (hit_x)     target_x_in     = '0;
               if (hit_y)     target_y_in     = '0;
               if (timer_limit_ff != '0) elapsed_in = elapsed_inc;
               if (tick_pend != '0) begin
                  elapsed_in = '0;
                  if (tick_pend[BIT_TRANS] || tick_pend[BIT_ROT]) begin
                     ref_x_in = in_x_ff;
                     ref_y_in = in_y_ff;
                     ref_a_in = in_a_ff;
                  end
               end
               pending_in  = tick_pend;
               rsp_warn_in = tick_pend;
            end
            ACT_ARM_ANGLE: target_angle_in = in_arm_ff[POS_W-1:0];
            ACT_ARM_X:     target_x_in     = in_arm_ff[POS_W-1:0];
            ACT_ARM_Y:     target_y_in     = in_arm_ff[POS_W-1:0];
            ACT_ARM_TIMER: timer_limit_in  = in_arm_ff[POS_W-1:0];
            ACT_ARM_TRANS: dist_limit_in   = arm_sq_sat;
            ACT_ARM_ROT:   rot_limit_in    = in_arm_ff[POS_W-1:0];
            ACT_INIT: begin
               target_angle_in = '0;
               target_x_in     = '0;
               target_y_in     = '0;
               timer_limit_in  = '0;
               dist_limit_in   = '0;
               rot_limit_in    = '0;
               elapsed_in      = '0;
               pending_in      = '0;
               rsp_warn_in     = '0;
               ref_x_in        = in_x_ff;
               ref_y_in        = in_y_ff;
               ref_a_in        = in_a_ff;
            end
            ACT_COLLECT: pending_in = '0;
            default: ;
         endcase
      end

      rsp_armed_in = '0;
      rsp_armed_in[BIT_ANGLE] = (target_angle_in != '0);
      rsp_armed_in[BIT_X]     = (target_x_in != '0);
      rsp_armed_in[BIT_Y]     = (target_y_in != '0);
      rsp_armed_in[BIT_TIMER] = (timer_limit_in != '0);
      rsp_armed_in[BIT_TRANS] = (dist_limit_in != '0);
      rsp_armed_in[BIT_ROT]   = (rot_limit_in != '0);
   end

   // Watcher state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_angle_ff <= '0;
         target_x_ff     <= '0;
         target_y_ff     <= '0;
         timer_limit_ff  <= '0;
         dist_limit_ff   <= '0;
         rot_limit_ff    <= '0;
         elapsed_ff      <= '0;
         ref_x_ff        <= '0;
         ref_y_ff        <= '0;
         ref_a_ff        <= '0;
         pending_ff      <= '0;
      end else begin
         target_angle_ff <= target_angle_in;
         target_x_ff     <= target_x_in;
         target_y_ff     <= target_y_in;
         timer_limit_ff  <= timer_limit_in;
         dist_limit_ff   <= dist_limit_in;
         rot_limit_ff    <= rot_limit_in;
         elapsed_ff      <= elapsed_in;
         ref_x_ff        <= ref_x_in;
         ref_y_ff        <= ref_y_in;
         ref_a_ff        <= ref_a_in;
         pending_ff      <= pending_in;
      end
   end

   // Result register: load on advance, drop when the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_warn_ff  <= rsp_warn_in;
         rsp_armed_ff <= rsp_armed_in;
      end
   end

   // Init leaves every watcher disarmed and nothing pending
   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (in_action_ff == ACT_INIT) |=>
         (rsp_armed_ff == '0) && (rsp_warn_ff == '0) && (pending_ff == '0))
      else $error("init did not clear watcher state");

   // Collect empties the pending bits
   a_collect_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (in_action_ff == ACT_COLLECT) |=> (pending_ff == '0))
      else $error("collect left pending bits");

   // A result only appears from a beat held in the input register
   a_rsp_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result raised without an input beat");

   // A stalled input beat stays in place
   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_action_ff))
      else $error("input beat lost while stalled");

endmodule

// ----- tb/position_event_watcher_core_tb.sv -----
`timescale 1ns / 1ps

module position_event_watcher_core_tb;
   import pevw_pkg::*;

   localparam int CLOCK_PERIOD     = 12;
   localparam int RESET_CYCLES     = 5;
   localparam int PHASES           = 5;
   localparam int RANDOM_PER_PHASE = 206;
   localparam int DIRECTED_N       = 24;
   localparam int LONG_HOLD        = 80;
   localparam int SETTLE_CYCLES    = 4;
   localparam int WATCHDOG_LIMIT   = 3000;
   // Highest action code; everything above collect is ignored by the block
   localparam logic [ACTION_W-1:0] ACT_RESERVED_TOP = 4'd15;

   typedef struct packed {
      logic [MASK_W-1:0] warn;
      logic [MASK_W-1:0] armed;
   } watch_report_type;

   typedef struct packed {
      logic [ACTION_W-1:0]    act;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pa;
      logic signed [ARM_W-1:0] av;
      logic                    typed;
      logic [MASK_W-1:0]       warn;
      logic [MASK_W-1:0]       armed;
   } stim_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [ACTION_W-1:0]     req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we;
   logic                    csr_index;
   logic [TOL_W-1:0]        csr_wdata;

   // Watcher state mirrored by the predictor
   logic [TOL_W-1:0]        ang_tol;
   logic [TOL_W-1:0]        pos_tol;
   logic signed [POS_W-1:0] tgt_angle;
   logic signed [POS_W-1:0] tgt_x;
   logic signed [POS_W-1:0] tgt_y;
   logic [15:0]             timer_limit;
   logic [31:0]             dist_sq_limit;
   logic signed [POS_W-1:0] rot_limit;
   logic [15:0]             elapsed_ms;
   logic signed [POS_W-1:0] org_x;
   logic signed [POS_W-1:0] org_y;
   logic signed [POS_W-1:0] org_angle;
   logic [MASK_W-1:0]       pending;

   // Wandering pose that random beats follow
   logic signed [POS_W-1:0] trk_x;
   logic signed [POS_W-1:0] trk_y;
   logic signed [POS_W-1:0] trk_a;

   watch_report_type expected_reports[$];
   int unsigned   mismatch_count;
   int unsigned   quiet_cycles;
   int            burst_left;
   bit            long_hold_req;

   position_event_watcher_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic int mag_of(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic void clear_watchers();
      tgt_angle     = '0;
      tgt_x         = '0;
      tgt_y         = '0;
      timer_limit   = '0;
      dist_sq_limit = '0;
      rot_limit     = '0;
      elapsed_ms    = '0;
      pending       = '0;
   endfunction

   // Apply one action to the mirrored state and return the report it produces
   function automatic watch_report_type apply_action(logic [ACTION_W-1:0] act,
                                                     logic signed [POS_W-1:0] px,
                                                     logic signed [POS_W-1:0] py,
                                                     logic signed [POS_W-1:0] pa,
                                                     logic signed [ARM_W-1:0] av);
      int               dx;
      int               dy;
      int               dr;
      longint           lim_sq;
      watch_report_type rep;
      case (act)
         ACT_TICK: begin
            if (tgt_angle != 0 && mag_of(int'(pa) - int'(tgt_angle)) <= int'(ang_tol)) begin
               tgt_angle = '0;
               pending[BIT_ANGLE] = 1'b1;
            end
            if (tgt_x != 0 && mag_of(int'(px) - int'(tgt_x)) < int'(pos_tol)) begin
               tgt_x = '0;
               pending[BIT_X] = 1'b1;
            end
            if (tgt_y != 0 && mag_of(int'(py) - int'(tgt_y)) < int'(pos_tol)) begin
               tgt_y = '0;
               pending[BIT_Y] = 1'b1;
            end
            if (timer_limit != 0) begin
               elapsed_ms = elapsed_ms + 16'(TICK_MS);
               if (elapsed_ms >= timer_limit) pending[BIT_TIMER] = 1'b1;
            end
            // full-width squared distance, never wraps
            if (dist_sq_limit != 0) begin
               dx = mag_of(int'(px) - int'(org_x));
               dy = mag_of(int'(py) - int'(org_y));
               if (longint'(dx) * dx + longint'(dy) * dy >= longint'(dist_sq_limit))
                  pending[BIT_TRANS] = 1'b1;
            end
            // fold heading change into one turn around zero
            if (rot_limit != 0) begin
               dr = int'(pa) - int'(org_angle);
               while (dr > HALF_TURN) dr = dr - FULL_TURN;
               while (dr < -HALF_TURN) dr = dr + FULL_TURN;
               if (mag_of(dr) > int'(rot_limit)) pending[BIT_ROT] = 1'b1;
            end
            if (pending != 0) begin
               elapsed_ms = '0;
               if (pending[BIT_TRANS] || pending[BIT_ROT]) begin
                  org_x     = px;
                  org_y     = py;
                  org_angle = pa;
               end
            end
         end
         ACT_ARM_ANGLE: tgt_angle = av[15:0];
         ACT_ARM_X:     tgt_x = av[15:0];
         ACT_ARM_Y:     tgt_y = av[15:0];
         ACT_ARM_TIMER: timer_limit = av[15:0];
         ACT_ARM_TRANS: begin
            dx = mag_of(int'(av));
            lim_sq = longint'(dx) * dx;
            dist_sq_limit = (lim_sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lim_sq[31:0];
         end
         ACT_ARM_ROT:   rot_limit = av[15:0];
         ACT_INIT: begin
            clear_watchers();
            org_x     = px;
            org_y     = py;
            org_angle = pa;
         end
         default: ;
      endcase
      rep.warn = pending;
      if (act == ACT_COLLECT) pending = '0;
      rep.armed[BIT_ANGLE] = (tgt_angle != 0);
      rep.armed[BIT_X]     = (tgt_x != 0);
      rep.armed[BIT_Y]     = (tgt_y != 0);
      rep.armed[BIT_TIMER] = (timer_limit != 0);
      rep.armed[BIT_TRANS] = (dist_sq_limit != 0);
      rep.armed[BIT_ROT]   = (rot_limit != 0);
      return rep;
   endfunction

   // Directed beats; tolerances are 100 (angle) and 50 (position) here
   function automatic stim_row_type directed_row(int i);
      stim_row_type r;
      r = '0;
      case (i)
         // nothing armed after reset, reserved code is a no-op
         0:  r = '{ACT_COLLECT, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 1'b1, 6'b0, 6'b0};
         1:  r = '{ACT_RESERVED_TOP, -16'sd1, -16'sd1, -16'sd1, -17'sd1, 1'b1, 6'b0, 6'b0};
         // arm every watcher, most with extreme values
         2:  r = '{ACT_ARM_ANGLE, 16'sd0, 16'sd0, 16'sd0, 17'sd1000, 1'b1, 6'b0, 6'b000001};
         3:  r = '{ACT_ARM_X, 16'sd0, 16'sd0, 16'sd0, -17'sd32768, 1'b1, 6'b0, 6'b000011};
         4:  r = '{ACT_ARM_Y, 16'sd0, 16'sd0, 16'sd0, 17'sd65535, 1'b1, 6'b0, 6'b000111};
         5:  r = '{ACT_ARM_TIMER, 16'sd0, 16'sd0, 16'sd0, 17'sd65535, 1'b1, 6'b0, 6'b001111};
         6:  r = '{ACT_ARM_TRANS, 16'sd0, 16'sd0, 16'sd0, 17'sd65535, 1'b1, 6'b0, 6'b011111};
         7:  r = '{ACT_ARM_ROT, 16'sd0, 16'sd0, 16'sd0, -17'sd1, 1'b1, 6'b0, 6'b111111};
         // negative rotation limit fires; opposite corners overflow 32 bits
         8:  r = '{ACT_TICK, 16'sd32767, -16'sd32768, -16'sd32768, 17'sd0, 1'b0, 6'b0, 6'b0};
         9:  r = '{ACT_TICK, -16'sd32768, 16'sd32767, 16'sd32767, 17'sd0, 1'b0, 6'b0, 6'b0};
         10: r = '{ACT_COLLECT, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 1'b0, 6'b0, 6'b0};
         11: r = '{ACT_INIT, -16'sd32768, 16'sd32767, -16'sd32768, 17'sd0, 1'b1, 6'b0, 6'b0};
         // angle window is inclusive
         12: r = '{ACT_ARM_ANGLE, 16'sd0, 16'sd0, 16'sd0, 17'sd2000, 1'b1, 6'b0, 6'b000001};
         13: r = '{ACT_TICK, 16'sd0, 16'sd0, 16'sd2101, 17'sd0, 1'b0, 6'b0, 6'b0};
         14: r = '{ACT_TICK, 16'sd0, 16'sd0, 16'sd2100, 17'sd0, 1'b0, 6'b0, 6'b0};
         // position window is exclusive
         15: r = '{ACT_ARM_Y, 16'sd0, 16'sd0, 16'sd0, 17'sd200, 1'b0, 6'b0, 6'b0};
         16: r = '{ACT_TICK, 16'sd0, 16'sd250, 16'sd0, 17'sd0, 1'b0, 6'b0, 6'b0};
         17: r = '{ACT_TICK, 16'sd0, 16'sd249, 16'sd0, 17'sd0, 1'b0, 6'b0, 6'b0};
         18: r = '{ACT_ARM_TIMER, 16'sd0, 16'sd0, 16'sd0, 17'sd5, 1'b0, 6'b0, 6'b0};
         19: r = '{ACT_TICK, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 1'b0, 6'b0, 6'b0};
         // heading change needs several wrap steps
         20: r = '{ACT_ARM_ROT, 16'sd0, 16'sd0, 16'sd0, 17'sd12868, 1'b0, 6'b0, 6'b0};
         21: r = '{ACT_TICK, 16'sd0, 16'sd0, 16'sd32767, 17'sd0, 1'b0, 6'b0, 6'b0};
         22: r = '{ACT_COLLECT, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 1'b0, 6'b0, 6'b0};
         23: r = '{ACT_ARM_TIMER, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 1'b0, 6'b0, 6'b0};
         default: ;
      endcase
      return r;
   endfunction

   // Mostly short gaps, some bursts with none, a few long ones
   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if (r < 3) burst_left = $urandom_range(20, 60);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // Build one random beat around the wandering pose
   task automatic pick_item(output logic [ACTION_W-1:0] act,
                            output logic signed [POS_W-1:0] px,
                            output logic signed [POS_W-1:0] py,
                            output logic signed [POS_W-1:0] pa,
                            output logic signed [ARM_W-1:0] av);
      int r;
      int kind;
      logic signed [POS_W-1:0] near;
      if ($urandom_range(0, 24) == 0) begin
         trk_x = 16'($urandom);
         trk_y = 16'($urandom);
         trk_a = 16'($urandom);
      end else begin
         trk_x = trk_x + 16'(int'($urandom_range(0, 60)) - 30);
         trk_y = trk_y + 16'(int'($urandom_range(0, 60)) - 30);
         trk_a = trk_a + 16'(int'($urandom_range(0, 120)) - 60);
      end
      px = trk_x;
      py = trk_y;
      pa = trk_a;
      av = 17'(int'($urandom_range(0, 98303)) - 32768);
      r = $urandom_range(0, 99);
      if (r < 50) begin
         act = ACT_TICK;
      end else if (r < 85) begin
         act = 4'(ACT_ARM_ANGLE) + 4'($urandom_range(0, 5));
         kind = $urandom_range(0, 5);
         // one in six disarms, one in six keeps the full random value
         if (kind == 0) begin
            av = '0;
         end else if (kind > 1) begin
            case (act)
               ACT_ARM_ANGLE: near = trk_a + 16'(int'($urandom_range(0, 400)) - 200);
               ACT_ARM_X:     near = trk_x + 16'(int'($urandom_range(0, 200)) - 100);
               ACT_ARM_Y:     near = trk_y + 16'(int'($urandom_range(0, 200)) - 100);
               ACT_ARM_TIMER: near = 16'($urandom_range(1, 60));
               ACT_ARM_TRANS: near = 16'($urandom_range(1, 300));
               default:       near = 16'($urandom_range(1, 3000));
            endcase
            av = {near[15], near};
         end
      end else if (r < 92) begin
         act = ACT_COLLECT;
      end else if (r < 96) begin
         act = ACT_INIT;
      end else begin
         act = 4'($urandom_range(9, 15));
      end
   endtask

   // Offer one beat, wait for the handshake and record its expected result
   task automatic send_beat(stim_row_type row);
      watch_report_type rep;
      req_tuser  <= row.act;
      req_tdata  <= REQ_DATA_W'({row.av, row.pa, row.py, row.px});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      rep = apply_action(row.act, row.px, row.py, row.pa, row.av);
      if (row.typed) begin
         rep.warn  = row.warn;
         rep.armed = row.armed;
      end
      expected_reports.push_back(rep);
   endtask

   task automatic gap_then_send(stim_row_type row);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      send_beat(row);
   endtask

   // Stop offering and wait until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tolerances(logic [TOL_W-1:0] a_tol, logic [TOL_W-1:0] p_tol);
      csr_we    <= 1'b1;
      csr_index <= CSR_ANGLE_TOL;
      csr_wdata <= a_tol;
      @(posedge clock);
      ang_tol = a_tol;
      csr_index <= CSR_POS_TOL;
      csr_wdata <= p_tol;
      @(posedge clock);
      pos_tol = p_tol;
      csr_we <= 1'b0;
   endtask

   // Stimulus: reset, then directed beats and random phases per tolerance setting
   initial begin
      stim_row_type row;
      logic [TOL_W-1:0] a_tol;
      logic [TOL_W-1:0] p_tol;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_ANGLE_TOL;
      csr_wdata      = '0;
      ang_tol        = '0;
      pos_tol        = '0;
      org_x          = '0;
      org_y          = '0;
      org_angle      = '0;
      trk_x          = '0;
      trk_y          = '0;
      trk_a          = '0;
      burst_left     = 0;
      long_hold_req  = 1'b0;
      mismatch_count = 0;
      clear_watchers();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin a_tol = 15'd100;   p_tol = 15'd50;    end
            1:       begin a_tol = 15'd0;     p_tol = 15'd0;     end
            2:       begin a_tol = 15'h7FFF;  p_tol = 15'h7FFF;  end
            3:       begin a_tol = 15'($urandom_range(0, 600));
                           p_tol = 15'($urandom_range(0, 300));  end
            default: begin a_tol = 15'($urandom); p_tol = 15'($urandom); end
         endcase
         if (phase > 0) drain_results();
         write_tolerances(a_tol, p_tol);

         if (phase == 0) begin
            for (int i = 0; i < DIRECTED_N; i++) gap_then_send(directed_row(i));
         end

         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            // stall the receiver while beats keep coming
            if (phase == 1 && i == 100) begin
               long_hold_req = 1'b1;
               burst_left    = 30;
            end
            // hold the sender until the block has emptied
            if (i == 150) drain_results();
            row = '0;
            pick_item(row.act, row.px, row.py, row.pa, row.av);
            gap_then_send(row);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS position_event_watcher_core");
      end else begin
         $display("FAIL position_event_watcher_core");
      end
      $finish;
   end

   // Result ready: random runs high and low, one long hold on request
   initial begin
      int r;
      rsp_tready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (r < 5) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(50, 150)) @(posedge clock);
         end else if (r < 55) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else if (r < 88) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else if (r < 98) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(4, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(15, 40)) @(posedge clock);
         end
      end
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin : check_results
      watch_report_type got;
      watch_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.warn  = rsp_tdata[5:0];
         got.armed = rsp_tdata[11:6];
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            $display("%0t: result beat expected none, got warning %b armed %b",
                     $time, got.warn, got.armed);
         end else begin
            want = expected_reports.pop_front();
            if (got.warn !== want.warn) begin
               mismatch_count++;
               $display("%0t: warning_mask expected %b, got %b",
                        $time, want.warn, got.warn);
            end
            if (got.armed !== want.armed) begin
               mismatch_count++;
               $display("%0t: armed_mask expected %b, got %b",
                        $time, want.armed, got.armed);
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL position_event_watcher_core");
            $finish;
         end
      end
   end

endmodule

// ----- filelist.f -----
hdl/pevw_pkg.sv
hdl/position_event_watcher_core.sv
tb/position_event_watcher_core_tb.sv
